// File: sv/bgtr_pkg.sv
// shared types, codes and defaults for the bitmap glyph text renderer
package bgtr_pkg;

  typedef logic signed [12:0] coord_t;
  typedef logic [2:0]         cfg_index_t;
  typedef logic [12:0]        cfg_data_t;

  // command codes carried in tuser
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_CHAR  = 2'd2;

  // register indexes
  localparam cfg_index_t REG_GLYPH_WIDTH      = 3'd0;
  localparam cfg_index_t REG_GLYPH_HEIGHT     = 3'd1;
  localparam cfg_index_t REG_FORE_COLOR       = 3'd2;
  localparam cfg_index_t REG_BACK_COLOR       = 3'd3;
  localparam cfg_index_t REG_TRANSPARENT_BACK = 3'd4;
  localparam cfg_index_t REG_CONTROL_CHARS    = 3'd5;
  localparam cfg_index_t REG_SCREEN_WIDTH     = 3'd6;
  localparam cfg_index_t REG_SCREEN_HEIGHT    = 3'd7;

  localparam logic [7:0] CODE_NEWLINE = 8'd10;
  localparam logic [7:0] CODE_TAB     = 8'd9;

  localparam logic [12:0] SCREEN_MAX = 13'd4096;
  localparam logic signed [13:0] CUR_MAX = 14'sd4095;
  localparam logic signed [13:0] CUR_MIN = -14'sd4096;

  localparam int GLYPH_COUNT_DEF      = 256;
  localparam int MAX_GLYPH_HEIGHT_DEF = 16;
  localparam int MAX_GLYPH_WIDTH_DEF  = 8;

  localparam logic [3:0]  RST_GLYPH_WIDTH   = 4'd8;
  localparam logic [4:0]  RST_GLYPH_HEIGHT  = 5'd16;
  localparam logic [7:0]  RST_FORE_COLOR    = 8'd15;
  localparam logic [7:0]  RST_BACK_COLOR    = 8'd0;
  localparam logic [12:0] RST_SCREEN_WIDTH  = 13'd640;
  localparam logic [12:0] RST_SCREEN_HEIGHT = 13'd480;

endpackage

// File: sv/bitmap_glyph_text_renderer.sv
// bitmap glyph text renderer: glyph store, text cursor and row command sequencer
//
//  channel  dir  handshake          payload
//  s_       in   s_tvalid/s_tready  s_tuser cmd, s_tdata char/row/bits/start
//  m_       out  m_tvalid/m_tready  m_tdata row command, m_tlast last_row
//  cfg_     in   cfg_we             cfg_index, cfg_data
//
// load and start items are taken in the idle state; newline, tab and glyphs with a code out
// of range or a negative column go to the advance state, glyphs clipped on the right pass
// clip-x then advance, glyphs clipped in y clip-x, clip-y then advance; a drawn glyph passes
// clip-x, clip-y, rows and advance, one row a cycle from the store read port while the output is not stalled
// the output register lets the last row wait while the next item is taken
// rst is synchronous and clears the cursor, the registers and the sequencer
module bitmap_glyph_text_renderer #(
  parameter int GLYPH_COUNT      = bgtr_pkg::GLYPH_COUNT_DEF,
  parameter int MAX_GLYPH_HEIGHT = bgtr_pkg::MAX_GLYPH_HEIGHT_DEF,
  parameter int MAX_GLYPH_WIDTH  = bgtr_pkg::MAX_GLYPH_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [47:0]          s_tdata,   // char_code, row_index, row_bits, start_x, start_y
  input  logic [1:0]           s_tuser,   // cmd
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [55:0]          m_tdata,   // pixel_x, pixel_y, ink_mask, paint_mask, fore_out, back_out
  output logic                 m_tlast,   // last_row
  input  logic                 cfg_we,
  input  bgtr_pkg::cfg_index_t cfg_index,
  input  bgtr_pkg::cfg_data_t  cfg_data
);

  import bgtr_pkg::*;

  localparam int DEPTH = GLYPH_COUNT * MAX_GLYPH_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW    = (MAX_GLYPH_HEIGHT > 1) ? $clog2(MAX_GLYPH_HEIGHT) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLIPX = 3'd1;
  localparam logic [2:0] S_CLIPY = 3'd2;
  localparam logic [2:0] S_ROWS  = 3'd3;
  localparam logic [2:0] S_ADV   = 3'd4;

  localparam logic [1:0] ADV_CELL = 2'd0;
  localparam logic [1:0] ADV_TAB  = 2'd1;
  localparam logic [1:0] ADV_LINE = 2'd2;

  logic [3:0]  glyph_width;
  logic [4:0]  glyph_height;
  logic [7:0]  fore_color;
  logic [7:0]  back_color;
  logic        transparent_back;
  logic        control_chars;
  logic [12:0] screen_width;
  logic [12:0] screen_height;

  logic [2:0]  state;
  logic [1:0]  adv_sel;
  coord_t      cursor_x;
  coord_t      cursor_y;
  coord_t      left_margin;
  logic [7:0]  code;
  logic [RW-1:0] icnt;
  logic        issuing;
  logic        rd_pend;
  logic        pend_last;
  logic [11:0] row_y;

  logic [1:0]  in_cmd;
  logic [7:0]  in_code;
  logic [3:0]  in_row;
  logic [7:0]  in_bits;
  coord_t      in_x;
  coord_t      in_y;
  logic        accept;

  logic [3:0]  eff_w;
  logic [4:0]  eff_h;
  logic [RW-1:0] h_m1;
  logic [12:0] eff_sw;
  logic [12:0] eff_sh;
  logic [2:0]  shamt;
  logic [7:0]  colmask;
  logic [7:0]  ink;

  coord_t      op_a;
  logic [5:0]  op_b;
  logic [12:0] op_lim;
  logic signed [13:0] sum;
  logic        sum_ge;
  coord_t      sum_sat;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic          issue;
  logic          load_out;
  logic          code_ok;

  assign in_cmd  = s_tuser;
  assign in_code = s_tdata[7:0];
  assign in_row  = s_tdata[11:8];
  assign in_bits = s_tdata[19:12];
  assign in_x    = s_tdata[32:20];
  assign in_y    = s_tdata[45:33];

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  // effective sizes
  always_comb begin
    priority if (glyph_width == 4'd0) begin
      eff_w = 4'd1;
    end else if (glyph_width > 4'(MAX_GLYPH_WIDTH)) begin
      eff_w = 4'(MAX_GLYPH_WIDTH);
    end else begin
      eff_w = glyph_width;
    end
    priority if (glyph_height == 5'd0) begin
      eff_h = 5'd1;
    end else if (glyph_height > 5'(MAX_GLYPH_HEIGHT)) begin
      eff_h = 5'(MAX_GLYPH_HEIGHT);
    end else begin
      eff_h = glyph_height;
    end
    eff_sw = (screen_width > SCREEN_MAX) ? SCREEN_MAX : screen_width;
    eff_sh = (screen_height > SCREEN_MAX) ? SCREEN_MAX : screen_height;
  end

  assign h_m1    = RW'(eff_h - 5'd1);
  assign shamt   = 3'(4'd8 - eff_w);
  assign colmask = 8'hFF << shamt;
  assign ink     = (rd_data << shamt) & colmask;
  assign code_ok = ({1'b0, in_code} < 9'(GLYPH_COUNT));

  // shared add, compare and saturate unit
  always_comb begin
    op_a   = cursor_x;
    op_b   = {2'd0, eff_w};
    op_lim = eff_sw;
    unique case (state)
      S_CLIPY: begin
        op_a   = cursor_y;
        op_b   = {1'b0, eff_h};
        op_lim = eff_sh;
      end
      S_ADV: begin
        unique case (adv_sel)
          ADV_TAB:  op_b = {eff_w, 2'd0};
          ADV_LINE: begin
            op_a = cursor_y;
            op_b = {1'b0, eff_h};
          end
          default:  op_b = {2'd0, eff_w};
        endcase
      end
      default: begin
        op_a = cursor_x;
      end
    endcase
  end

  always_comb begin
    sum    = $signed({op_a[12], op_a}) + $signed({8'd0, op_b});
    sum_ge = (sum >= $signed({1'b0, op_lim}));
    priority if (sum > CUR_MAX) begin
      sum_sat = CUR_MAX[12:0];
    end else if (sum < CUR_MIN) begin
      sum_sat = CUR_MIN[12:0];
    end else begin
      sum_sat = sum[12:0];
    end
  end

  // glyph store
  assign wr_en    = accept && (in_cmd == CMD_LOAD) && code_ok &&
                    ({1'b0, in_row} < 5'(MAX_GLYPH_HEIGHT));
  assign wr_addr  = AW'(int'(in_code) * MAX_GLYPH_HEIGHT + int'(in_row));
  assign rd_addr  = AW'(int'(code) * MAX_GLYPH_HEIGHT + int'(icnt));
  assign load_out = rd_pend && (!m_tvalid || m_tready);
  assign issue    = issuing && (!rd_pend || load_out);

  bgtr_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (in_bits),
    .re    (issue),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_width      <= RST_GLYPH_WIDTH;
      glyph_height     <= RST_GLYPH_HEIGHT;
      fore_color       <= RST_FORE_COLOR;
      back_color       <= RST_BACK_COLOR;
      transparent_back <= 1'b1;
      control_chars    <= 1'b1;
      screen_width     <= RST_SCREEN_WIDTH;
      screen_height    <= RST_SCREEN_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GLYPH_WIDTH:      glyph_width      <= cfg_data[3:0];
        REG_GLYPH_HEIGHT:     glyph_height     <= cfg_data[4:0];
        REG_FORE_COLOR:       fore_color       <= cfg_data[7:0];
        REG_BACK_COLOR:       back_color       <= cfg_data[7:0];
        REG_TRANSPARENT_BACK: transparent_back <= cfg_data[0];
        REG_CONTROL_CHARS:    control_chars    <= cfg_data[0];
        REG_SCREEN_WIDTH:     screen_width     <= cfg_data;
        REG_SCREEN_HEIGHT:    screen_height    <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      adv_sel     <= ADV_CELL;
      cursor_x    <= '0;
      cursor_y    <= '0;
      left_margin <= '0;
      issuing     <= 1'b0;
      icnt        <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept && in_cmd == CMD_START) begin
            cursor_x    <= in_x;
            cursor_y    <= in_y;
            left_margin <= in_x;
          end
          if (accept && in_cmd == CMD_CHAR) begin
            code <= in_code;
            priority if (control_chars && in_code == CODE_NEWLINE) begin
              adv_sel <= ADV_LINE;
              state   <= S_ADV;
            end else if (control_chars && in_code == CODE_TAB) begin
              adv_sel <= ADV_TAB;
              state   <= S_ADV;
            end else begin
              adv_sel <= ADV_CELL;
              state   <= (code_ok && !cursor_x[12]) ? S_CLIPX : S_ADV;
            end
          end
        end
        S_CLIPX: begin
          state <= sum_ge ? S_ADV : S_CLIPY;
        end
        S_CLIPY: begin
          if (sum_ge || cursor_y[12]) begin
            state <= S_ADV;
          end else begin
            state   <= S_ROWS;
            issuing <= 1'b1;
            icnt    <= '0;
          end
        end
        S_ROWS: begin
          if (issue) begin
            if (icnt == h_m1) begin
              issuing <= 1'b0;
            end else begin
              icnt <= icnt + 1'b1;
            end
          end
          if (!issuing && !rd_pend) begin
            state <= S_ADV;
          end
        end
        S_ADV: begin
          state <= S_IDLE;
          unique case (adv_sel)
            ADV_LINE: begin
              cursor_y <= sum_sat;
              cursor_x <= left_margin;
            end
            default:  cursor_x <= sum_sat;
          endcase
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // read pipeline and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (issue) begin
        rd_pend <= 1'b1;
      end else if (load_out) begin
        rd_pend <= 1'b0;
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      pend_last <= (icnt == h_m1);
    end
    if (state == S_CLIPY) begin
      row_y <= cursor_y[11:0];
    end else if (load_out) begin
      row_y <= row_y + 12'd1;
    end
    if (load_out) begin
      m_tdata[11:0]  <= cursor_x[11:0];
      m_tdata[23:12] <= row_y;
      m_tdata[31:24] <= ink;
      m_tdata[39:32] <= transparent_back ? ink : colmask;
      m_tdata[47:40] <= fore_color;
      m_tdata[55:48] <= transparent_back ? 8'd0 : back_color;
      m_tlast        <= pend_last;
    end
  end

  a_pend_in_rows: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> state == S_ROWS)
    else $error("store read pending outside row phase");

  a_issue_in_rows: assert property (@(posedge clk) disable iff (rst)
    issuing |-> state == S_ROWS)
    else $error("row issue active outside row phase");

  a_adv_after_rows: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROWS && !issuing && !rd_pend) |=> state == S_ADV)
    else $error("row phase did not close into cursor advance");

endmodule

// File: sv/bgtr_ram.sv
// generic simple dual-port ram with registered read
module bgtr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sim/bgtr_checker.sv
// row command predictor and result checker for the bitmap glyph text renderer
module bgtr_checker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [47:0]          s_tdata,   // char_code, row_index, row_bits, start_x, start_y
  input  logic [1:0]           s_tuser,   // cmd
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [55:0]          m_tdata,   // pixel_x, pixel_y, ink_mask, paint_mask, fore_out, back_out
  input  logic                 m_tlast,   // last_row
  input  logic                 cfg_we,
  input  bgtr_pkg::cfg_index_t cfg_index,
  input  bgtr_pkg::cfg_data_t  cfg_data,
  output int                   fails,
  output int                   pending
);

  import bgtr_pkg::*;

  localparam int TAB_CELLS = 4;
  localparam int SHOWN_MAX = 10;

  typedef struct packed {
    logic [11:0] px;
    logic [11:0] py;
    logic [7:0]  ink;
    logic [7:0]  paint;
    logic [7:0]  fore;
    logic [7:0]  back;
    logic        last;
  } row_cmd_t;

  logic [7:0]  glyph_rows [0:GLYPH_COUNT_DEF*MAX_GLYPH_HEIGHT_DEF-1];
  row_cmd_t    rows_due [$];
  int          cur_x;
  int          cur_y;
  int          margin;
  logic [3:0]  cell_w_reg;
  logic [4:0]  cell_h_reg;
  logic [7:0]  ink_color;
  logic [7:0]  paper_color;
  logic        see_through;
  logic        ctl_mode;
  logic [12:0] scr_w;
  logic [12:0] scr_h;
  int          n_bad = 0;

  function automatic int sat_coord(input int v);
    if (v > CUR_MAX) return CUR_MAX;
    if (v < CUR_MIN) return CUR_MIN;
    return v;
  endfunction

  function automatic string fmt_row(input row_cmd_t r);
    return $sformatf("x=%0d y=%0d ink=%02h paint=%02h fore=%02h back=%02h last=%0b",
                     r.px, r.py, r.ink, r.paint, r.fore, r.back, r.last);
  endfunction

  task automatic take_item(input logic [1:0] op, input logic [47:0] d);
    logic [7:0] code;
    logic [7:0] bits;
    logic [7:0] colmask;
    logic [7:0] ink;
    logic [3:0] row;
    int         w;
    int         h;
    int         sw;
    int         sh;
    int         yr;
    row_cmd_t   rc;
    code = d[7:0];
    row  = d[11:8];
    bits = d[19:12];
    w  = (cell_w_reg == 0) ? 1 :
         (cell_w_reg > MAX_GLYPH_WIDTH_DEF) ? MAX_GLYPH_WIDTH_DEF : cell_w_reg;
    h  = (cell_h_reg == 0) ? 1 :
         (cell_h_reg > MAX_GLYPH_HEIGHT_DEF) ? MAX_GLYPH_HEIGHT_DEF : cell_h_reg;
    sw = (scr_w > SCREEN_MAX) ? SCREEN_MAX : scr_w;
    sh = (scr_h > SCREEN_MAX) ? SCREEN_MAX : scr_h;
    case (op)
      CMD_LOAD: glyph_rows[{code, row}] = bits;
      CMD_START: begin
        cur_x  = $signed(d[32:20]);
        cur_y  = $signed(d[45:33]);
        margin = cur_x;
      end
      CMD_CHAR: begin
        if (ctl_mode && code == CODE_NEWLINE) begin
          cur_y = sat_coord(cur_y + h);
          cur_x = margin;
        end else if (ctl_mode && code == CODE_TAB) begin
          cur_x = sat_coord(cur_x + TAB_CELLS * w);
        end else begin
          // glyphs touching the screen edge are dropped whole
          if (cur_x >= 0 && cur_y >= 0 && cur_x + w < sw && cur_y + h < sh) begin
            colmask = 8'hFF << (MAX_GLYPH_WIDTH_DEF - w);
            for (int r = 0; r < h; r++) begin
              ink = (glyph_rows[{code, r[3:0]}] << (MAX_GLYPH_WIDTH_DEF - w)) & colmask;
              yr = cur_y + r;
              rc.px    = cur_x[11:0];
              rc.py    = yr[11:0];
              rc.ink   = ink;
              rc.paint = see_through ? ink : colmask;
              rc.fore  = ink_color;
              rc.back  = see_through ? 8'h00 : paper_color;
              rc.last  = (r == h - 1);
              rows_due.push_back(rc);
            end
          end
          cur_x = sat_coord(cur_x + w);
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_row();
    row_cmd_t got;
    row_cmd_t want;
    got.px    = m_tdata[11:0];
    got.py    = m_tdata[23:12];
    got.ink   = m_tdata[31:24];
    got.paint = m_tdata[39:32];
    got.fore  = m_tdata[47:40];
    got.back  = m_tdata[55:48];
    got.last  = m_tlast;
    if (rows_due.size() == 0) begin
      n_bad++;
      if (n_bad <= SHOWN_MAX) $display("unexpected row command: %s", fmt_row(got));
    end else begin
      want = rows_due.pop_front();
      if (got !== want) begin
        n_bad++;
        if (n_bad <= SHOWN_MAX)
          $display("row command mismatch: expected %s, got %s", fmt_row(want), fmt_row(got));
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rows_due.delete();
      cur_x       = 0;
      cur_y       = 0;
      margin      = 0;
      cell_w_reg  = RST_GLYPH_WIDTH;
      cell_h_reg  = RST_GLYPH_HEIGHT;
      ink_color   = RST_FORE_COLOR;
      paper_color = RST_BACK_COLOR;
      see_through = 1'b1;
      ctl_mode    = 1'b1;
      scr_w       = RST_SCREEN_WIDTH;
      scr_h       = RST_SCREEN_HEIGHT;
    end else begin
      if (m_tvalid && m_tready) check_row();
      if (cfg_we) begin
        case (cfg_index)
          REG_GLYPH_WIDTH:      cell_w_reg  = cfg_data[3:0];
          REG_GLYPH_HEIGHT:     cell_h_reg  = cfg_data[4:0];
          REG_FORE_COLOR:       ink_color   = cfg_data[7:0];
          REG_BACK_COLOR:       paper_color = cfg_data[7:0];
          REG_TRANSPARENT_BACK: see_through = cfg_data[0];
          REG_CONTROL_CHARS:    ctl_mode    = cfg_data[0];
          REG_SCREEN_WIDTH:     scr_w       = cfg_data;
          REG_SCREEN_HEIGHT:    scr_h       = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) take_item(s_tuser, s_tdata);
    end
    pending <= rows_due.size();
    fails   <= n_bad;
  end

endmodule

// File: sim/bitmap_glyph_text_renderer_tb.sv
// testbench top for the bitmap glyph text renderer: clock, reset, stimulus and verdict
module bitmap_glyph_text_renderer_tb;
  import bgtr_pkg::*;

  typedef enum logic [1:0] {RX_OPEN, RX_HALF, RX_CHOKED} rx_mode_t;

  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam int GLYPH_ZERO = 0;
  localparam int GLYPH_A    = 65;
  localparam int GLYPH_LAST = 255;
  localparam int DRAIN_CYCLES = 32;
  localparam int PHASE_ITEMS  = 12;
  localparam int PHASES       = 10;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;   // char_code, row_index, row_bits, start_x, start_y
  logic [1:0]  s_tuser = CMD_LOAD;   // cmd
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;   // pixel_x, pixel_y, ink_mask, paint_mask, fore_out, back_out
  logic        m_tlast;   // last_row
  logic        cfg_we = 1'b0;
  cfg_index_t  cfg_index = REG_GLYPH_WIDTH;
  cfg_data_t   cfg_data = '0;
  int          fails;
  int          pending_rows;

  rx_mode_t    rx_mode = RX_OPEN;
  int          rx_left = 0;
  int          burst_left = 0;
  int          n_sent = 0;
  logic [15:0] rows_loaded [0:255];
  bit          is_ready [0:255];
  int          ready_glyphs [$];
  logic        ctl_on = 1'b1;
  int          x_lim = 639;
  int          y_lim = 479;
  int          seed_glyphs [5] = '{GLYPH_ZERO, CODE_TAB, CODE_NEWLINE, GLYPH_A, GLYPH_LAST};

  always #5 clk = ~clk;

  bitmap_glyph_text_renderer u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  bgtr_checker u_chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fails(fails), .pending(pending_rows)
  );

  // receiver stalls in stretches of open, patchy and mostly blocked
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 2));
      rx_left <= $urandom_range(1, 64);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN: m_tready <= 1'b1;
      RX_HALF: m_tready <= ($urandom_range(0, 1) == 1);
      default: m_tready <= ($urandom_range(0, 4) == 0);
    endcase
  end

  function automatic logic [47:0] rand_item();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return {2'b00, r[45:0]};
  endfunction

  task automatic push(input logic [1:0] op, input logic [47:0] d);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= d;
    do @(posedge clk); while (!s_tready);
    n_sent++;
  endtask

  task automatic send_load(input int code, input int row, input int bits);
    logic [47:0] d;
    d = rand_item();
    d[7:0]   = code[7:0];
    d[11:8]  = row[3:0];
    d[19:12] = bits[7:0];
    rows_loaded[code[7:0]][row[3:0]] = 1'b1;
    if (rows_loaded[code[7:0]] == 16'hFFFF && !is_ready[code[7:0]]) begin
      is_ready[code[7:0]] = 1'b1;
      ready_glyphs.push_back(code[7:0]);
    end
    push(CMD_LOAD, d);
  endtask

  task automatic send_start(input int x, input int y);
    logic [47:0] d;
    d = rand_item();
    d[32:20] = x[12:0];
    d[45:33] = y[12:0];
    push(CMD_START, d);
  endtask

  task automatic send_char(input int code);
    logic [47:0] d;
    d = rand_item();
    d[7:0] = code[7:0];
    push(CMD_CHAR, d);
  endtask

  task automatic send_noise();
    push(CMD_SPARE, rand_item());
  endtask

  // only fully loaded glyphs are ever drawn
  function automatic int pick_char();
    if (ctl_on && $urandom_range(0, 5) == 0)
      return ($urandom_range(0, 1) == 1) ? CODE_NEWLINE : CODE_TAB;
    return ready_glyphs[$urandom_range(0, ready_glyphs.size() - 1)];
  endfunction

  task automatic write_reg(input cfg_index_t idx, input int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[12:0];
    @(posedge clk);
  endtask

  task automatic apply_setting(input int w, input int h, input int fg, input int bg,
                               input int tr, input int ctl, input int sw, input int sh);
    int sw_eff;
    int sh_eff;
    write_reg(REG_GLYPH_WIDTH, w);
    write_reg(REG_GLYPH_HEIGHT, h);
    write_reg(REG_FORE_COLOR, fg);
    write_reg(REG_BACK_COLOR, bg);
    write_reg(REG_TRANSPARENT_BACK, tr);
    write_reg(REG_CONTROL_CHARS, ctl);
    write_reg(REG_SCREEN_WIDTH, sw);
    write_reg(REG_SCREEN_HEIGHT, sh);
    cfg_we <= 1'b0;
    ctl_on = ctl[0];
    sw_eff = (sw[12:0] > SCREEN_MAX) ? SCREEN_MAX : sw[12:0];
    sh_eff = (sh[12:0] > SCREEN_MAX) ? SCREEN_MAX : sh[12:0];
    x_lim  = (sw_eff > 4095) ? 4095 : sw_eff;
    y_lim  = (sh_eff > 4095) ? 4095 : sh_eff;
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_rows != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_chunk();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      if ($urandom_range(0, 9) == 0)
        send_start(x_lim - $urandom_range(0, 10), y_lim - $urandom_range(0, 20));
      else
        send_start($urandom_range(0, x_lim), $urandom_range(0, y_lim));
      repeat ($urandom_range(1, 8)) send_char(pick_char());
    end else if (pick < 60) begin
      send_load($urandom_range(0, 255), 0, $urandom_range(0, 255));
      for (int r = 1; r < MAX_GLYPH_HEIGHT_DEF; r++)
        send_load(ready_glyphs.size() > 0 ? $urandom_range(0, 255) : 0, r, 0);
    end else if (pick < 75) begin
      send_load($urandom_range(0, 255), $urandom_range(0, 15), $urandom_range(0, 255));
    end else if (pick < 82) begin
      send_char(pick_char());
    end else if (pick < 94) begin
      send_start($urandom_range(0, 8191), $urandom_range(0, 8191));
      repeat ($urandom_range(1, 3)) send_char(pick_char());
    end else begin
      send_noise();
    end
  endtask

  initial begin
    int base;
    int p;
    int code;
    foreach (rows_loaded[i]) rows_loaded[i] = '0;
    foreach (is_ready[i]) is_ready[i] = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (seed_glyphs[i])
      for (int r = 0; r < MAX_GLYPH_HEIGHT_DEF; r++)
        send_load(seed_glyphs[i], r,
                  (seed_glyphs[i] == GLYPH_ZERO) ? 0 :
                  (seed_glyphs[i] == GLYPH_LAST) ? 255 : $urandom_range(0, 255));

    // edges, control characters, clipping and cursor saturation at reset settings
    send_start(0, 0);
    send_char(GLYPH_ZERO);
    send_char(GLYPH_LAST);
    send_char(GLYPH_A);
    send_char(CODE_NEWLINE);
    send_char(CODE_TAB);
    send_char(GLYPH_A);
    send_noise();
    send_start(631, 463);
    send_char(GLYPH_A);
    send_char(GLYPH_A);
    send_start(-1, 0);
    send_char(GLYPH_A);
    send_start(0, -1);
    send_char(GLYPH_A);
    send_start(4095, 4095);
    send_char(GLYPH_A);
    send_char(CODE_TAB);
    send_char(CODE_NEWLINE);
    send_start(-4096, -4096);
    send_char(GLYPH_LAST);
    send_start(0, 464);
    send_char(GLYPH_ZERO);
    send_load(GLYPH_A, 15, 8'hA5);
    send_start(8, 8);
    send_char(GLYPH_A);

    for (p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        settle();
        case (p)
          1: apply_setting(1, 1, 0, 255, 0, 0, 4096, 4096);
          2: apply_setting(0, 0, 255, 0, 1, 1, 0, 0);
          3: apply_setting(15, 31, $urandom_range(0, 255), $urandom_range(0, 255),
                           0, 1, 8191, 8191);
          4: apply_setting(8, 16, 170, 85, 0, 0, 16, 32);
          5: apply_setting(5, 7, 1, 2, 1, 1, 1, 4096);
          default: apply_setting($urandom_range(0, 15), $urandom_range(0, 31),
                                 $urandom_range(0, 255), $urandom_range(0, 255),
                                 $urandom_range(0, 1), $urandom_range(0, 1),
                                 ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191)
                                                             : $urandom_range(24, 640),
                                 ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191)
                                                             : $urandom_range(24, 480));
        endcase
      end
      base = n_sent;
      while (n_sent - base < PHASE_ITEMS) begin
        if ($urandom_range(0, 19) == 0) begin
          // a whole glyph of a random code so the drawable set can keep growing
          code = $urandom_range(0, 255);
          for (int r = 0; r < MAX_GLYPH_HEIGHT_DEF; r++)
            send_load(code, r, $urandom_range(0, 255));
        end else begin
          random_chunk();
        end
      end
    end

    settle();
    if (fails == 0 && pending_rows == 0) begin
      $display("bitmap_glyph_text_renderer test passed");
    end else begin
      $display("bitmap_glyph_text_renderer test failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("bitmap_glyph_text_renderer test failed");
    $finish;
  end

endmodule

// File: sim.f
sv/bgtr_pkg.sv
sv/bgtr_ram.sv
sv/bitmap_glyph_text_renderer.sv
sim/bgtr_checker.sv
sim/bitmap_glyph_text_renderer_tb.sv
